// ===== rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted-table binary search block.
// No dependencies; used by stbs_ctrl, stbs_dp and the top level.
package stbs_pkg;

  localparam int IDX_W   = 10;  // index fields on the ports
  localparam int DATA_W  = 32;  // table entry and key width
  localparam int PROBE_W = 4;   // probe counter, 1..12
  localparam int BND_W   = 12;  // interval bounds: hi may reach -1, lo may reach 1024

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Input item
  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         write_index;
    logic signed [DATA_W-1:0] entry_data;
    logic [IDX_W-1:0]         low_index;
    logic [IDX_W-1:0]         high_index;
    logic signed [DATA_W-1:0] search_key;
  } stbs_in_t;

  // Result item
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   position;
    logic [PROBE_W-1:0] probe_count;
  } stbs_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic write;   // store entry_data at write_index
    logic load;    // capture a new search interval and key
    logic probe;   // read the midpoint entry, count the probe
    logic step;    // narrow the interval after a miss
    logic finish;  // load the result register
  } stbs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;   // current interval has lo above hi
    logic hit;     // probed entry equals the key
  } stbs_sts_t;

endpackage

// ===== rtl/stbs_ctrl.sv =====
// Search controller: sequences write, probe and compare steps and owns
// the result valid flag. Depends on stbs_pkg.
module stbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  output logic                out_valid,
  input  logic                out_ready,
  input  stbs_pkg::stbs_sts_t sts,
  output stbs_pkg::stbs_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // result register can take a new item this cycle
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == stbs_pkg::OP_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (sts.empty) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.finish ? 1'b1 : (out_valid_r && !out_ready);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/stbs_dp.sv =====
// Search datapath: table memory, interval bounds, midpoint, compare and
// result register. Depends on stbs_pkg.
module stbs_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  stbs_pkg::stbs_in_t   in_item,
  input  stbs_pkg::stbs_cmd_t  cmd,
  output stbs_pkg::stbs_sts_t  sts,
  output stbs_pkg::stbs_out_t  out_item
);

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MAX_IDX = TABLE_DEPTH - 1;
  localparam int IW      = stbs_pkg::IDX_W;
  localparam int BW      = stbs_pkg::BND_W;
  localparam int PW      = stbs_pkg::PROBE_W;
  localparam int DW      = stbs_pkg::DATA_W;

  logic signed [DW-1:0] mem_r [TABLE_DEPTH];
  logic signed [DW-1:0] rdata_r;
  logic signed [DW-1:0] key_r;
  logic [BW-1:0]        lo_r;
  logic [BW-1:0]        hi_r;
  logic [BW-1:0]        mid_r;
  logic [PW-1:0]        probes_r;
  stbs_pkg::stbs_out_t  out_item_r;

  logic [IW-1:0] hi_sat;
  logic [BW-1:0] diff;
  logic [BW-1:0] mid_nxt;
  logic          wr_in_range;
  logic          key_below;

  // clamp the upper bound to the last table slot
  assign hi_sat = (32'(in_item.high_index) > MAX_IDX) ? IW'(MAX_IDX) : in_item.high_index;
  assign wr_in_range = (32'(in_item.write_index) < TABLE_DEPTH);

  // midpoint lo + (hi - lo) / 2, used only while the interval is not empty
  assign diff    = hi_r - lo_r;
  assign mid_nxt = lo_r + {1'b0, diff[BW-1:1]};

  // status toward the controller
  assign sts.empty = ($signed(lo_r) > $signed(hi_r));
  assign sts.hit   = (rdata_r == key_r);
  assign key_below = (rdata_r > key_r);

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write && wr_in_range) begin
      mem_r[AW'(in_item.write_index)] <= in_item.entry_data;
    end
    if (cmd.probe) begin
      rdata_r <= mem_r[AW'(mid_nxt)];
    end
  end

  // interval, key and probe counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r     <= BW'(in_item.low_index);
      hi_r     <= BW'(hi_sat);
      key_r    <= in_item.search_key;
      probes_r <= '0;
    end else if (cmd.probe) begin
      mid_r    <= mid_nxt;
      probes_r <= probes_r + PW'(1);
    end else if (cmd.step) begin
      if (key_below) begin
        hi_r <= mid_r - BW'(1);
      end else begin
        lo_r <= mid_r + BW'(1);
      end
    end
  end

  // result register; the empty-interval probe is counted here
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (sts.empty) begin
        out_item_r.found       <= 1'b0;
        out_item_r.position    <= '0;
        out_item_r.probe_count <= probes_r + PW'(1);
      end else begin
        out_item_r.found       <= 1'b1;
        out_item_r.position    <= mid_r[IW-1:0];
        out_item_r.probe_count <= probes_r;
      end
    end
  end

  assign out_item = out_item_r;

endmodule

// ===== rtl/sorted_table_binary_search_top.sv =====
// Top level of the sorted-table binary search: controller plus datapath.
// Depends on stbs_pkg, stbs_ctrl and stbs_dp.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_ready, in_item    | write or search item
//   result  | out_valid, out_ready, out_item | found, position, probe_count
//
// A write item is stored from S_IDLE. A search item is loaded from S_IDLE,
// then alternates S_PROBE (a table read through the registered memory port)
// and S_CMP (its compare) for P reads, at most 11. A found key finishes from
// S_CMP, an absent one from S_PROBE once the interval is empty. The next item
// is taken once the controller is back in S_IDLE, so a search holds the input
// until its result loads. Reset clears only control state; table contents are
// not cleared and must be written before they are searched. A result held by
// a stalled out_ready blocks only the finishing step of the next search.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stbs_pkg::stbs_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output stbs_pkg::stbs_out_t out_item
);

  stbs_pkg::stbs_cmd_t cmd;
  stbs_pkg::stbs_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_item.op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
